// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/fcct_pkg.sv =====
package fcct_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CLU_W       = 28;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 13;

    // Allocation word codes
    localparam logic [CLU_W-1:0]  EOC_LIMIT  = 28'hFFFFFF8;
    localparam logic [WORD_W-1:0] EOC_MARK   = 32'hFFFFFFF8;
    localparam logic [WORD_W-1:0] EOC_RESULT = 32'hFFFFFFFF;

    // Operation codes
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_ALLOC  = 2'd2;
    localparam logic [1:0] KIND_FREE   = 2'd3;

    // Configuration register indexes
    localparam logic REG_READY = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOOK_WAIT,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/fat_cluster_chain_table_unit.sv =====
// FAT32 cluster allocation table with one operation per input transaction and one
// result transaction per operation. After reset a clearing pass zeroes all
// TABLE_DEPTH (4096) words, one word per cycle; input transactions stall during it while
// configuration writes are taken at any time (cfg_ready is always high). Operations run
// one at a time through a single-port table memory with a registered read. A lookup
// that is refused or out of range skips the table read; an allocate scans the words
// from cluster 2 while below cluster_count and TABLE_DEPTH, and a free walks its chain,
// zeroing each word, for at most TABLE_DEPTH links. Allocate and free refused while
// the table is not ready skip the table. The one memory port serves one read or one
// write per cycle, and every scanned or visited word needs a read-then-check pair of
// states. A finished result waits in the output register while the next transaction
// is accepted.
`include "assert_macros.svh"

module fat_cluster_chain_table_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [fcct_pkg::CLU_W-1:0]     cluster,
    input  logic [fcct_pkg::WORD_W-1:0]    entry_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           status,
    output logic [fcct_pkg::WORD_W-1:0]    cluster_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [fcct_pkg::COUNT_W-1:0]   cfg_data
);
    import fcct_pkg::*;

    localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CLU_W-1:0] DEPTH_C  = CLU_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic                 ready_cfg_reg;
    logic [COUNT_W-1:0]   cluster_count_reg;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [IDX_W-1:0]     steps_reg, steps_next;
    logic [1:0]           kind_reg, kind_next;
    logic [CLU_W-1:0]     cur_reg, cur_next;
    logic [WORD_W-1:0]    value_reg, value_next;
    logic                 res_status_reg, res_status_next;
    logic [WORD_W-1:0]    res_value_reg, res_value_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_status_reg, out_status_next;
    logic [WORD_W-1:0]    out_value_reg, out_value_next;

    logic [WORD_W-1:0]    mem [TABLE_DEPTH];
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_addr;
    logic [WORD_W-1:0]    mem_wdata;

    logic                 accept;
    logic                 out_free;
    logic                 cur_in_depth;
    logic                 cur_in_lim;
    logic [CLU_W-1:0]     rd_masked;
    logic                 rd_eoc;

    logic                 chk_alloc_wr;
    logic                 chk_free_wr;
    logic                 chk_resp_go;

    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign cluster_out = out_value_reg;
    assign cfg_ready   = 1'b1;
    assign out_free    = !out_valid_reg || !out_stall;

    // Shared range compare and end-of-chain decode
    assign cur_in_depth = (cur_reg < DEPTH_C);
    assign cur_in_lim   = cur_in_depth && (cur_reg < {{(CLU_W-COUNT_W){1'b0}}, cluster_count_reg});
    assign rd_masked    = rd_data_reg[CLU_W-1:0];
    assign rd_eoc       = (rd_masked >= EOC_LIMIT);

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_cfg_reg     <= 1'b0;
            cluster_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_READY: ready_cfg_reg     <= cfg_data[0];
                REG_COUNT: cluster_count_reg <= cfg_data;
                default:   ready_cfg_reg     <= ready_cfg_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        steps_reg      <= steps_next;
        kind_reg       <= kind_next;
        cur_reg        <= cur_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == DEPTH_M1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (kind_reg)
                    KIND_LOOKUP:
                        state_next = (ready_cfg_reg && cur_in_lim) ? ST_LOOK_WAIT : ST_RESP;
                    KIND_ALLOC:
                        state_next = ready_cfg_reg ? ST_ALLOC_RD : ST_RESP;
                    KIND_FREE:
                        state_next = ready_cfg_reg ? ST_FREE_RD : ST_RESP;
                    default:
                        state_next = ST_RESP;
                endcase
            end
            ST_LOOK_WAIT:
                state_next = ST_RESP;
            ST_ALLOC_RD:
                state_next = cur_in_lim ? ST_ALLOC_CHK : ST_RESP;
            ST_ALLOC_CHK:
                state_next = (rd_data_reg == '0) ? ST_RESP : ST_ALLOC_RD;
            ST_FREE_RD:
                state_next = cur_in_lim ? ST_FREE_CHK : ST_RESP;
            ST_FREE_CHK:
                state_next = (rd_eoc || steps_reg == DEPTH_M1) ? ST_RESP : ST_FREE_RD;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        clr_next        = clr_reg;
        steps_next      = steps_reg;
        kind_next       = kind_reg;
        cur_next        = cur_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        mem_we          = 1'b0;
        mem_addr        = cur_reg[IDX_W-1:0];
        mem_wdata       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep zeros through the table
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                // Capture the transaction
                if (accept)
                begin
                    kind_next  = kind;
                    cur_next   = cluster;
                    value_next = entry_value;
                end
            end
            ST_DECODE:
            begin
                res_status_next = 1'b0;
                res_value_next  = '0;
                case (kind_reg)
                    KIND_LOAD:
                    begin
                        // Drop loads beyond the table
                        if (cur_in_depth)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = value_reg;
                        end
                    end
                    KIND_LOOKUP:
                    begin
                        if (!(ready_cfg_reg && cur_in_lim))
                        begin
                            res_value_next = EOC_RESULT;
                        end
                    end
                    KIND_ALLOC:
                        cur_next = CLU_W'(2);
                    KIND_FREE:
                    begin
                        res_status_next = !ready_cfg_reg;
                        steps_next      = '0;
                    end
                    default:
                        res_value_next = '0;
                endcase
            end
            ST_LOOK_WAIT:
            begin
                res_value_next = rd_eoc ? EOC_RESULT : {{(WORD_W-CLU_W){1'b0}}, rd_masked};
            end
            ST_ALLOC_CHK:
            begin
                // Claim the first zero word, else advance the scan
                if (rd_data_reg == '0)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = EOC_MARK;
                    res_value_next = {{(WORD_W-CLU_W){1'b0}}, cur_reg};
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            ST_FREE_RD:
            begin
                // Out of the volume: zero the word if it exists and stop
                if (!cur_in_lim && cur_in_depth)
                begin
                    mem_we = 1'b1;
                end
            end
            ST_FREE_CHK:
            begin
                // Zero the visited word and follow its link
                mem_we     = 1'b1;
                cur_next   = rd_masked;
                steps_next = steps_reg + 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                end
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    // Checks
    assign chk_alloc_wr = (state_reg == ST_ALLOC_CHK) && mem_we;
    assign chk_free_wr  = ((state_reg == ST_FREE_RD) || (state_reg == ST_FREE_CHK)) && mem_we;
    assign chk_resp_go  = (state_reg == ST_RESP) && out_free;

    `CHK_NEXT(a_accept_decodes, accept, state_reg == ST_DECODE)
    `CHK_IMPLY(a_alloc_claims_zero, chk_alloc_wr, (rd_data_reg == '0) && (mem_wdata == EOC_MARK))
    `CHK_IMPLY(a_free_writes_zero, chk_free_wr, mem_wdata == '0)
    `CHK_NEXT(a_resp_loads_out, chk_resp_go, out_valid_reg && out_value_reg == $past(res_value_reg))

endmodule

// ===== sim/fcct_checker.sv =====
// Watches the channels of the allocation table, keeps a shadow copy of the
// table and the registers, and compares every result transaction with the
// oldest one owed.
module fcct_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     kind,
    input  logic [fcct_pkg::CLU_W-1:0]     cluster,
    input  logic [fcct_pkg::WORD_W-1:0]    entry_value,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           status,
    input  logic [fcct_pkg::WORD_W-1:0]    cluster_out,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [fcct_pkg::COUNT_W-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import fcct_pkg::*;

    typedef struct packed {
        logic              status;
        logic [WORD_W-1:0] cluster_out;
    } fat_reply_t;

    localparam logic [WORD_W-1:0] CLUSTER_MASK = 32'h0FFFFFFF;

    logic [WORD_W-1:0]  fat_shadow [TABLE_DEPTH];
    logic               ready_q;
    logic [COUNT_W-1:0] count_q;
    fat_reply_t         owed_replies [$];

    // Clusters below this bound are reachable by lookups and the allocation scan
    function automatic int scan_bound();
        return (count_q < TABLE_DEPTH) ? int'(count_q) : TABLE_DEPTH;
    endfunction

    // Follow one link of a chain, folding every terminal case into end-of-chain
    function automatic logic [WORD_W-1:0] next_link(input logic [WORD_W-1:0] idx);
        logic [WORD_W-1:0] masked;
        if (!ready_q || idx >= scan_bound())
            return EOC_RESULT;
        masked = fat_shadow[idx[IDX_W-1:0]] & CLUSTER_MASK;
        if (masked >= {4'd0, EOC_LIMIT})
            return EOC_RESULT;
        return masked;
    endfunction

    // Apply one operation to the shadow table and return the reply it owes
    function automatic fat_reply_t run_fat_op(input logic [1:0] op,
                                              input logic [CLU_W-1:0] clu,
                                              input logic [WORD_W-1:0] word);
        fat_reply_t        reply;
        logic [WORD_W-1:0] cur;
        logic [WORD_W-1:0] nxt;
        reply = '0;
        case (op)
            KIND_LOAD:
            begin
                if (clu < TABLE_DEPTH)
                    fat_shadow[clu[IDX_W-1:0]] = word;
            end
            KIND_LOOKUP:
            begin
                reply.cluster_out = next_link({4'd0, clu});
            end
            KIND_ALLOC:
            begin
                if (ready_q)
                begin
                    for (int i = 2; i < scan_bound(); i++)
                    begin
                        if (fat_shadow[i] == '0)
                        begin
                            fat_shadow[i] = EOC_MARK;
                            reply.cluster_out = i;
                            break;
                        end
                    end
                end
            end
            default:
            begin
                if (!ready_q)
                begin
                    reply.status = 1'b1;
                end
                else
                begin
                    // Walk and zero the chain, bounded so a looped chain ends
                    cur = {4'd0, clu};
                    for (int s = 0; s < TABLE_DEPTH; s++)
                    begin
                        nxt = next_link(cur);
                        if (cur < TABLE_DEPTH)
                            fat_shadow[cur[IDX_W-1:0]] = '0;
                        if (nxt == EOC_RESULT)
                            break;
                        cur = nxt;
                    end
                end
            end
        endcase
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fat_reply_t owed;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                fat_shadow[i] = '0;
            ready_q = 1'b0;
            count_q = '0;
            owed_replies.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            // Compare the result transaction with the oldest owed reply
            if (out_valid && !out_stall)
            begin
                if (owed_replies.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: status=%0d cluster_out=%08h",
                                 status, cluster_out);
                    fail_count++;
                end
                else
                begin
                    owed = owed_replies.pop_front();
                    if (status !== owed.status || cluster_out !== owed.cluster_out)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %0d %08h, got %0d %08h",
                                     owed.status, owed.cluster_out, status, cluster_out);
                        fail_count++;
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_READY)
                    ready_q = cfg_data[0];
                else
                    count_q = cfg_data;
            end

            // Predict the reply of each accepted operation
            if (in_valid && !in_stall)
                owed_replies.push_back(run_fat_op(kind, cluster, entry_value));

            pending_results = owed_replies.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fcct_pkg::*;

    localparam int RANDOM_ITEMS = 105;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          kind;
    logic [CLU_W-1:0]    cluster;
    logic [WORD_W-1:0]   entry_value;
    logic                out_valid;
    logic                out_stall;
    logic                status;
    logic [WORD_W-1:0]   cluster_out;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [COUNT_W-1:0]  cfg_data;
    int                  fail_count;
    int                  pending_results;

    int                  items_sent;
    int                  calm_left;
    int                  cur_count;

    fat_cluster_chain_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .cluster     (cluster),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cluster_out (cluster_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    fcct_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .cluster         (cluster),
        .entry_value     (entry_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .cluster_out     (cluster_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly short, a few long
    function automatic int pick_gap(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Upper end of the interesting cluster range: one past the count, at most TABLE_DEPTH-1; 15 if count < 3
    function automatic int cluster_hi();
        if (cur_count < 3)
            return 15;
        return (cur_count + 1 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : cur_count + 1;
    endfunction

    function automatic logic [CLU_W-1:0] pick_cluster();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return CLU_W'($urandom_range(0, cluster_hi()));
        if (r < 85)
            return CLU_W'(TABLE_DEPTH - 1 + $urandom_range(0, 4));
        return CLU_W'($urandom());
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, cluster_hi());
        if (r < 70)
            return {4'($urandom()), EOC_LIMIT + 28'($urandom_range(0, 7))};
        if (r < 80)
            return '0;
        return $urandom();
    endfunction

    // Send one operation transaction and hold it until accepted
    task automatic drive_op(input logic [1:0] op, input logic [CLU_W-1:0] clu,
                            input logic [WORD_W-1:0] word);
        int gap;
        in_valid    <= 1'b1;
        kind        <= op;
        cluster     <= clu;
        entry_value <= word;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        @(negedge clk);
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap(50);
            if ($urandom_range(0, 19) == 0)
                calm_left = $urandom_range(5, 20);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Write one configuration register
    task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == REG_COUNT)
            cur_count = int'(data);
    endtask

    // Drop valid and wait until every owed result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Build a short linked chain, walk it by lookups, then free or allocate
    task automatic build_chain();
        int                len;
        logic [CLU_W-1:0]  links [8];
        len = $urandom_range(2, 6);
        for (int i = 0; i < len; i++)
            links[i] = CLU_W'($urandom_range(2, cluster_hi()));
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                drive_op(KIND_LOAD, links[i],
                         ($urandom_range(0, 1) == 0) ? EOC_MARK : 32'h0FFFFFFF);
            else
                drive_op(KIND_LOAD, links[i], {4'($urandom()), links[i+1]});
        end
        for (int i = 0; i < len; i++)
            if ($urandom_range(0, 1) == 0)
                drive_op(KIND_LOOKUP, links[i], pick_word());
        if ($urandom_range(0, 2) != 0)
            drive_op(KIND_FREE, links[0], pick_word());
        else
            drive_op(KIND_ALLOC, pick_cluster(), pick_word());
    endtask

    // Result side stall pattern, with occasional long free-running stretches
    initial
    begin
        int run;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 30);
            repeat (run) @(negedge clk);
            hold = pick_gap(0);
            out_stall <= 1'b1;
            repeat (hold) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int                 r;
        int                 phase_items;
        logic [COUNT_W-1:0] phase_counts [7];
        logic               phase_ready  [7];
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_LOAD;
        cluster     = '0;
        entry_value = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_READY;
        cfg_data    = '0;
        items_sent  = 0;
        calm_left   = 0;
        cur_count   = 0;
        phase_counts = '{13'd64, 13'd4096, 13'd2, 13'd37, 13'd1, 13'd0, 13'd4095};
        phase_ready  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        phase_counts[5] = COUNT_W'($urandom_range(3, 300));

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Operations refused while the table is not ready; loads still land, but those beyond the table are dropped
        write_reg(REG_COUNT, 13'd16);
        drive_op(KIND_LOOKUP, 28'd2, '0);
        drive_op(KIND_ALLOC, 28'd0, '0);
        drive_op(KIND_FREE, 28'd2, '0);
        drive_op(KIND_LOAD, 28'd2, 32'd3);
        drive_op(KIND_LOAD, 28'd3, 32'h0FFFFFF7);
        drive_op(KIND_LOAD, 28'd4, EOC_MARK);
        drive_op(KIND_LOAD, 28'h0FFFFFF, 32'hFFFFFFFF);
        drive_op(KIND_LOAD, CLU_W'(TABLE_DEPTH), 32'h12345678);
        drain();

        // Lookups: plain link, highest link, end-of-chain word, out of range, masked top bits
        write_reg(REG_READY, 13'd1);
        drive_op(KIND_LOOKUP, 28'd2, '0);
        drive_op(KIND_LOOKUP, 28'd3, '0);
        drive_op(KIND_LOOKUP, 28'd4, '0);
        drive_op(KIND_LOOKUP, 28'd0, '0);
        drive_op(KIND_LOOKUP, 28'h0FFFFFF, '0);
        drive_op(KIND_LOOKUP, 28'd16, '0);
        drive_op(KIND_LOAD, 28'd7, 32'hF0000005);
        drive_op(KIND_LOOKUP, 28'd7, '0);
        // Allocate the lowest free word, then free a looped chain
        drive_op(KIND_ALLOC, 28'd0, '0);
        drive_op(KIND_LOAD, 28'd5, 32'd6);
        drive_op(KIND_LOAD, 28'd6, 32'd5);
        drive_op(KIND_FREE, 28'd5, '0);
        // Free ending on a link past the table, and one starting past the count
        drive_op(KIND_FREE, 28'd2, '0);
        drive_op(KIND_LOAD, 28'd20, 32'd4);
        drive_op(KIND_FREE, 28'd20, '0);
        drain();

        // Allocate with no free word in range, then allocate and look up at counts of 0 and 4096
        write_reg(REG_COUNT, 13'd3);
        drive_op(KIND_LOAD, 28'd2, 32'd1);
        drive_op(KIND_ALLOC, 28'd0, '0);
        drain();
        write_reg(REG_COUNT, 13'd0);
        drive_op(KIND_ALLOC, 28'd0, '0);
        drive_op(KIND_LOOKUP, 28'd0, '0);
        drain();
        write_reg(REG_COUNT, 13'd4096);
        drive_op(KIND_ALLOC, 28'd0, '0);
        drive_op(KIND_LOOKUP, 28'd4095, '0);

        // Random phases, each under its own register setting
        items_sent = 0;
        for (int p = 0; p < 7; p++)
        begin
            drain();
            write_reg(REG_READY, COUNT_W'(phase_ready[p]));
            write_reg(REG_COUNT, phase_counts[p]);
            phase_items = items_sent;
            while (items_sent - phase_items < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    build_chain();
                else if (r < 50)
                    drive_op(KIND_LOAD, pick_cluster(), pick_word());
                else if (r < 75)
                    drive_op(KIND_LOOKUP, pick_cluster(), pick_word());
                else if (r < 88)
                    drive_op(KIND_ALLOC, pick_cluster(), pick_word());
                else
                    drive_op(KIND_FREE, pick_cluster(), pick_word());
            end
        end

        drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("PASS fat_cluster_chain_table_unit");
        else
            $display("FAIL fat_cluster_chain_table_unit");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("FAIL fat_cluster_chain_table_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fcct_pkg.sv
rtl/fat_cluster_chain_table_unit.sv
sim/fcct_checker.sv
sim/tb_top.sv
